[rtl/symmetric_complex_fir_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the symmetric complex FIR
// Same-cycle and next-cycle implication checks. Defining NO_ASSERTIONS turns
// every use into empty text.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_COMPLEX_FIR_ASSERT_SVH
`define SYMMETRIC_COMPLEX_FIR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SFIR_ASSERT_SAME(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);
`define SFIR_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);
`else
`define SFIR_ASSERT_SAME(label, clk, rst, cond, conseq, msg)
`define SFIR_ASSERT_NEXT(label, clk, rst, cond, conseq, msg)
`endif
`endif

[rtl/sfir_pkg.sv]
// ----------------------------------------------------------------------------
// Symmetric complex FIR package
// Sizes, word types and control groups shared by the filter cells and MACs.
// ----------------------------------------------------------------------------
package sfir_pkg;

   // Odd span: the centre sits one past the lower half of the delay line.
   localparam int TAP_SPAN   = 63;
   localparam int HALF_SPAN  = TAP_SPAN / 2;
   localparam int STEP_W     = $clog2(HALF_SPAN);
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int COEF_IDX_W = 5;
   localparam int FRAC_SHIFT = 15;
   localparam int PAIR_W     = SAMPLE_W + 1;
   localparam int PROD_W     = COEF_W + PAIR_W;
   // Only accumulator bits FRAC_SHIFT and up to the output width matter.
   localparam int ACC_W      = FRAC_SHIFT + SAMPLE_W;

   localparam logic ACTION_FILTER = 1'b0;
   localparam logic ACTION_COEF   = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
   } sample_type;

   typedef struct packed {
      logic shift;
      logic rotate;
   } cell_ctrl_type;

   typedef struct packed {
      logic write;
      logic rotate;
   } coef_ctrl_type;

   typedef struct packed {
      logic run;
      logic first;
      logic use_tap;
   } mac_ctrl_type;

endpackage

[rtl/sfir_cell.sv]
// ----------------------------------------------------------------------------
// Delay line cell
// Holds one complex sample. Takes its neighbor's sample on a shift, or the
// ring neighbor's sample while the ring rotates past the MAC taps.
// ----------------------------------------------------------------------------
module sfir_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  sfir_pkg::cell_ctrl_type ctrl,
   input  sfir_pkg::sample_type   shift_in,
   input  sfir_pkg::sample_type   rot_in,
   output sfir_pkg::sample_type   data_out
);
   import sfir_pkg::*;

   sample_type data_ff;
   sample_type data_in;

   always_comb begin
      priority if (ctrl.shift) begin
         data_in = shift_in;
      end else if (ctrl.rotate) begin
         data_in = rot_in;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

[rtl/sfir_coef_cell.sv]
// ----------------------------------------------------------------------------
// Coefficient cell
// Holds one coefficient of the ring. Loaded by a coefficient write, passed to
// its neighbor while the ring rotates.
// ----------------------------------------------------------------------------
module sfir_coef_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  sfir_pkg::coef_ctrl_type          ctrl,
   input  logic signed [sfir_pkg::COEF_W-1:0] wr_data,
   input  logic signed [sfir_pkg::COEF_W-1:0] rot_in,
   output logic signed [sfir_pkg::COEF_W-1:0] data_out
);
   import sfir_pkg::*;

   logic signed [COEF_W-1:0] coef_ff;
   logic signed [COEF_W-1:0] coef_in;

   always_comb begin
      priority if (ctrl.write) begin
         coef_in = wr_data;
      end else if (ctrl.rotate) begin
         coef_in = rot_in;
      end else begin
         coef_in = coef_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign data_out = coef_ff;

endmodule

[rtl/sfir_mac.sv]
// ----------------------------------------------------------------------------
// Folded multiply-accumulate lane
// One step per cycle while run is high: coefficient times the symmetric
// pair (or centre sample on the first step), registered, then accumulated.
// ----------------------------------------------------------------------------
module sfir_mac (
   input  logic                               clock,
   input  sfir_pkg::mac_ctrl_type             ctrl,
   input  logic signed [sfir_pkg::COEF_W-1:0]   coef,
   input  logic signed [sfir_pkg::SAMPLE_W-1:0] centre,
   input  logic signed [sfir_pkg::SAMPLE_W-1:0] lower,
   input  logic signed [sfir_pkg::SAMPLE_W-1:0] upper,
   output logic signed [sfir_pkg::SAMPLE_W-1:0] result
);
   import sfir_pkg::*;

   logic signed [PAIR_W-1:0] pair;
   logic signed [PROD_W-1:0] product;
   logic signed [ACC_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]  prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  total;

   always_comb begin
      if (ctrl.first) begin
         pair = {centre[SAMPLE_W-1], centre};
      end else begin
         pair = {lower[SAMPLE_W-1], lower} + {upper[SAMPLE_W-1], upper};
      end
      product = coef * pair;
      // The accumulator wraps: bits above the output field never reach it.
      prod_in = ctrl.use_tap ? signed'(product[ACC_W-1:0]) : '0;
      acc_in  = ctrl.first ? '0 : acc_ff + prod_ff;
      total   = acc_ff + prod_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.run) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
      end
   end

   assign result = total[ACC_W-1:FRAC_SHIFT];

endmodule

[rtl/symmetric_complex_fir.sv]
// ----------------------------------------------------------------------------
// Symmetric complex FIR filter
// Folded FIR over a ring of delay cells with one complex MAC pair.
// ----------------------------------------------------------------------------
// Input words arrive on req_*. A filter word gives one output word on rsp_*,
// the filtered sample centred on the sample from 32 filter words back; a
// coefficient word loads one coefficient and gives nothing.
// csr_halfband_mode selects halfband operation; write it only while idle.
// Each filter word is accepted in the idle state, then runs through
// 31 MAC steps, one per coefficient, while the two halves of the delay line
// and the coefficient ring rotate past the MAC taps, then through a last
// step that adds the last product, loads the output register and shifts the
// new sample in. The output word is valid once that last step is done, and
// req_ready returns in that same cycle.
// A coefficient word is taken without leaving the idle state.
// Reset clears the delay line, all coefficients and the halfband mode.
// The output register holds a word until it is taken; a new word may be
// accepted meanwhile, and the block waits in its last step while rsp_ready
// stays low with an older word still unread.
// ----------------------------------------------------------------------------
module symmetric_complex_fir (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic [sfir_pkg::COEF_IDX_W-1:0]      req_coef_index,
   input  logic signed [sfir_pkg::COEF_W-1:0]   req_coef_value,
   input  logic signed [sfir_pkg::SAMPLE_W-1:0] req_sample_re,
   input  logic signed [sfir_pkg::SAMPLE_W-1:0] req_sample_im,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [sfir_pkg::SAMPLE_W-1:0] rsp_out_re,
   output logic signed [sfir_pkg::SAMPLE_W-1:0] rsp_out_im,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_halfband_mode
);
   import sfir_pkg::*;

   `include "symmetric_complex_fir_assert.svh"

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       halfband_ff, halfband_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   sample_type                 sample_ff, sample_in;
   logic signed [SAMPLE_W-1:0] out_re_ff, out_re_in;
   logic signed [SAMPLE_W-1:0] out_im_ff, out_im_in;

   logic          req_accept;
   logic          filter_accept;
   logic          coef_accept;
   logic          running;
   logic          drain_go;
   cell_ctrl_type ring_ctrl;
   cell_ctrl_type centre_ctrl;
   mac_ctrl_type  mac_ctrl;

   sample_type                 lo_q [HALF_SPAN];
   sample_type                 hi_q [HALF_SPAN];
   sample_type                 centre_q;
   logic signed [COEF_W-1:0]   cf_q [HALF_SPAN];
   logic signed [SAMPLE_W-1:0] sum_re;
   logic signed [SAMPLE_W-1:0] sum_im;

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_accept    = req_valid && req_ready;
   assign filter_accept = req_accept && (req_action == ACTION_FILTER);
   assign coef_accept   = req_accept && (req_action == ACTION_COEF);
   assign running       = (state_ff == ST_RUN);
   assign drain_go      = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready     = 1'b1;

   assign ring_ctrl   = '{shift: drain_go, rotate: running};
   assign centre_ctrl = '{shift: drain_go, rotate: 1'b0};

   // In halfband mode the even offsets drop out; the centre always counts.
   assign mac_ctrl.run     = running;
   assign mac_ctrl.first   = (step_ff == '0);
   assign mac_ctrl.use_tap = !(halfband_ff && !step_ff[0] && (step_ff != '0));

   // Lower half, lags 1 up to the centre. Rotation runs toward higher lags,
   // so cell 0 shows lag (centre - step) during the MAC steps.
   for (genvar i = 0; i < HALF_SPAN; i++) begin : g_lower
      sample_type shift_src;
      sample_type rot_src;
      if (i == 0) begin : g_head
         assign shift_src = sample_ff;
         assign rot_src   = lo_q[HALF_SPAN-1];
      end else begin : g_body
         assign shift_src = lo_q[i-1];
         assign rot_src   = lo_q[i-1];
      end
      sfir_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ring_ctrl),
         .shift_in (shift_src),
         .rot_in   (rot_src),
         .data_out (lo_q[i])
      );
   end

   sfir_cell u_centre (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (centre_ctrl),
      .shift_in (lo_q[HALF_SPAN-1]),
      .rot_in   (centre_q),
      .data_out (centre_q)
   );

   // Upper half, lags above the centre. Rotation runs toward lower lags, so
   // the last cell shows lag (centre + step) during the MAC steps.
   for (genvar j = 0; j < HALF_SPAN; j++) begin : g_upper
      sample_type shift_src;
      sample_type rot_src;
      if (j == 0) begin : g_head
         assign shift_src = centre_q;
      end else begin : g_body
         assign shift_src = hi_q[j-1];
      end
      if (j == HALF_SPAN - 1) begin : g_wrap
         assign rot_src = hi_q[0];
      end else begin : g_link
         assign rot_src = hi_q[j+1];
      end
      sfir_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ring_ctrl),
         .shift_in (shift_src),
         .rot_in   (rot_src),
         .data_out (hi_q[j])
      );
   end

   // Coefficient ring: cell 0 shows coefficient (step) during the MAC steps.
   for (genvar k = 0; k < HALF_SPAN; k++) begin : g_coef
      coef_ctrl_type            cctrl;
      logic signed [COEF_W-1:0] rot_src;
      assign cctrl.write  = coef_accept && (req_coef_index == COEF_IDX_W'(k));
      assign cctrl.rotate = running;
      if (k == HALF_SPAN - 1) begin : g_wrap
         assign rot_src = cf_q[0];
      end else begin : g_link
         assign rot_src = cf_q[k+1];
      end
      sfir_coef_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cctrl),
         .wr_data  (req_coef_value),
         .rot_in   (rot_src),
         .data_out (cf_q[k])
      );
   end

   sfir_mac u_mac_re (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .coef   (cf_q[0]),
      .centre (centre_q.re),
      .lower  (lo_q[0].re),
      .upper  (hi_q[HALF_SPAN-1].re),
      .result (sum_re)
   );

   sfir_mac u_mac_im (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .coef   (cf_q[0]),
      .centre (centre_q.im),
      .lower  (lo_q[0].im),
      .upper  (hi_q[HALF_SPAN-1].im),
      .result (sum_im)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      halfband_in  = halfband_ff;
      rsp_valid_in = rsp_valid_ff;
      sample_in    = sample_ff;
      out_re_in    = out_re_ff;
      out_im_in    = out_im_ff;

      if (csr_valid && csr_ready) begin
         halfband_in = csr_halfband_mode;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (filter_accept) begin
               sample_in = '{re: req_sample_re, im: req_sample_im};
               step_in   = '0;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            if (step_ff == STEP_W'(HALF_SPAN - 1)) begin
               step_in  = '0;
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (drain_go) begin
               out_re_in    = sum_re;
               out_im_in    = sum_im;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         halfband_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         halfband_ff  <= halfband_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      out_re_ff <= out_re_in;
      out_im_ff <= out_im_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_re = out_re_ff;
   assign rsp_out_im = out_im_ff;

   `SFIR_ASSERT_SAME(a_step_idle, clock, reset, state_ff != ST_RUN, step_ff == '0,
      "step counter moved outside the MAC steps")
   `SFIR_ASSERT_NEXT(a_filter_starts, clock, reset, filter_accept,
      (state_ff == ST_RUN) && (step_ff == '0), "filter word did not start the MAC steps")
   `SFIR_ASSERT_SAME(a_rsp_from_drain, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_DRAIN, "output word appeared outside the final step")
   `SFIR_ASSERT_NEXT(a_coef_keeps_line, clock, reset, coef_accept, $stable(centre_q),
      "coefficient word moved the delay line")

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Testbench for the symmetric complex FIR
// Drives filter and coefficient words through the request channel and writes
// the halfband mode between phases. A local model of the delay line and the
// coefficient table predicts every output word, and each output word is
// compared field by field with the oldest prediction still due.
// ----------------------------------------------------------------------------
module tb_top;
   import sfir_pkg::*;

   localparam int CENTRE_LAG    = TAP_SPAN - HALF_SPAN;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int PHASE_WORDS   = 250;
   localparam bit MODE_FULL     = 1'b0;
   localparam bit MODE_HALFBAND = 1'b1;

   typedef struct {
      logic                       action;
      logic [COEF_IDX_W-1:0]      coef_index;
      logic signed [COEF_W-1:0]   coef_value;
      sample_type                 sample;
   } fir_word_type;

   logic                       clock             = 1'b0;
   logic                       reset             = 1'b1;
   logic                       req_valid         = 1'b0;
   logic                       req_ready;
   logic                       req_action        = ACTION_FILTER;
   logic [COEF_IDX_W-1:0]      req_coef_index    = '0;
   logic signed [COEF_W-1:0]   req_coef_value    = '0;
   logic signed [SAMPLE_W-1:0] req_sample_re     = '0;
   logic signed [SAMPLE_W-1:0] req_sample_im     = '0;
   logic                       rsp_valid;
   logic                       rsp_ready         = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_out_re;
   logic signed [SAMPLE_W-1:0] rsp_out_im;
   logic                       csr_valid         = 1'b0;
   logic                       csr_ready;
   logic                       csr_halfband_mode = 1'b0;

   // Model state: index 0 of each line holds the previous filter sample.
   logic signed [SAMPLE_W-1:0] line_re [TAP_SPAN];
   logic signed [SAMPLE_W-1:0] line_im [TAP_SPAN];
   logic signed [COEF_W-1:0]   coef_tab [HALF_SPAN];
   bit                         halfband_model;

   sample_type filtered_due[$];
   sample_type oldest;
   int         error_count   = 0;
   int         cycle_count   = 0;
   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;

   symmetric_complex_fir dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_coef_index    (req_coef_index),
      .req_coef_value    (req_coef_value),
      .req_sample_re     (req_sample_re),
      .req_sample_im     (req_sample_im),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_re        (rsp_out_re),
      .rsp_out_im        (rsp_out_im),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_halfband_mode (csr_halfband_mode)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (filtered_due.size() == 0) begin
            $error("output word with none due: out_re=%0d out_im=%0d", rsp_out_re, rsp_out_im);
            error_count++;
         end else begin
            oldest = filtered_due.pop_front();
            if (rsp_out_re !== oldest.re) begin
               $error("out_re mismatch: expected %0d, actual %0d", oldest.re, rsp_out_re);
               error_count++;
            end
            if (rsp_out_im !== oldest.im) begin
               $error("out_im mismatch: expected %0d, actual %0d", oldest.im, rsp_out_im);
               error_count++;
            end
         end
      end
   end

   function automatic longint tap_at(input bit imag, input int lag);
      return longint'(imag ? line_im[lag-1] : line_re[lag-1]);
   endfunction

   // The shift by 15 followed by truncation to 16 bits keeps bits 30..15.
   function automatic logic signed [SAMPLE_W-1:0] fir_sum(input bit imag);
      longint acc;
      acc = longint'(coef_tab[0]) * tap_at(imag, CENTRE_LAG);
      for (int k = 1; k < HALF_SPAN; k++) begin
         if (halfband_model && (k % 2 == 0)) continue;
         acc += longint'(coef_tab[k]) *
                (tap_at(imag, CENTRE_LAG - k) + tap_at(imag, CENTRE_LAG + k));
      end
      return acc[FRAC_SHIFT +: SAMPLE_W];
   endfunction

   function automatic logic signed [15:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) begin
         unique case ($urandom_range(3))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'shFFFF;
         endcase
      end else if (roll < 40) begin
         return 16'($signed($urandom_range(511)) - 256);
      end
      return 16'($urandom);
   endfunction

   // Unused fields get random content; the block must ignore them.
   function automatic fir_word_type coef_word(input int idx, input logic signed [15:0] val);
      fir_word_type w;
      w.action     = ACTION_COEF;
      w.coef_index = idx[COEF_IDX_W-1:0];
      w.coef_value = val;
      w.sample.re  = 16'($urandom);
      w.sample.im  = 16'($urandom);
      return w;
   endfunction

   function automatic fir_word_type sample_word(input logic signed [15:0] re,
                                                input logic signed [15:0] im);
      fir_word_type w;
      w.action     = ACTION_FILTER;
      w.coef_index = 5'($urandom);
      w.coef_value = 16'($urandom);
      w.sample.re  = re;
      w.sample.im  = im;
      return w;
   endfunction

   task automatic send_word(input fir_word_type w);
      sample_type due;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= w.action;
      req_coef_index <= w.coef_index;
      req_coef_value <= w.coef_value;
      req_sample_re  <= w.sample.re;
      req_sample_im  <= w.sample.im;
      do @(posedge clock); while (!req_ready);
      if (w.action == ACTION_COEF) begin
         if (w.coef_index < HALF_SPAN) coef_tab[w.coef_index] = w.coef_value;
      end else begin
         due.re = fir_sum(1'b0);
         due.im = fir_sum(1'b1);
         filtered_due.push_back(due);
         for (int i = TAP_SPAN - 1; i > 0; i--) begin
            line_re[i] = line_re[i-1];
            line_im[i] = line_im[i-1];
         end
         line_re[0] = w.sample.re;
         line_im[0] = w.sample.im;
      end
   endtask

   // A coefficient word gives no output, so the block may still be busy once
   // the last output word is in; the settle cycles cover the filter pass.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (filtered_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_halfband(input bit mode);
      wait_idle();
      @(negedge clock);
      csr_valid         <= 1'b1;
      csr_halfband_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      halfband_model = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_stream(input bit mode, input int idle_pct, input int stall_pct);
      fir_word_type w;
      int           sent;
      int           pause_at;
      write_halfband(mode);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent     = 0;
      pause_at = $urandom_range(PHASE_WORDS - 20, 20);
      while (sent < PHASE_WORDS) begin
         if ($urandom_range(99) < 12) begin
            w = coef_word($urandom_range(31), pick_value());
         end else begin
            w = sample_word(pick_value(), pick_value());
         end
         send_word(w);
         if (w.action == ACTION_FILTER || w.coef_index < HALF_SPAN) sent++;
         if (sent == pause_at) wait_idle();
      end
   endtask

   task automatic test_edge_words();
      write_halfband(MODE_FULL);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_word(sample_word(16'sh7FFF, 16'sh8000));
      send_word(coef_word(0, 16'sh8000));
      send_word(coef_word(HALF_SPAN - 1, 16'sh7FFF));
      send_word(coef_word(21, 16'sh5555));
      send_word(coef_word(10, 16'shAAAA));
      send_word(coef_word(1, 16'sh4000));
      // Index 31 lies past the table and must leave every coefficient alone.
      send_word(coef_word(31, 16'sh1234));
      send_word(sample_word(16'sh8000, 16'sh7FFF));
      send_word(sample_word(16'sh0000, 16'shFFFF));
      send_word(sample_word(16'shFFFF, 16'sh0000));
      send_word(sample_word(16'sh5555, 16'shAAAA));
      send_word(sample_word(16'sh7FFF, 16'sh7FFF));
      send_word(sample_word(16'sh8000, 16'sh8000));
      send_word(coef_word(2, 16'sh7FFF));
      send_word(coef_word(3, 16'sh8000));
      send_word(sample_word(16'sh8000, 16'sh7FFF));
      send_word(sample_word(16'sh7FFF, 16'sh8000));
      send_word(sample_word(16'sh0001, 16'shFFFE));
      send_word(sample_word(16'sh7FFF, 16'sh7FFF));
      send_word(sample_word(16'sh8000, 16'sh8000));
   endtask

   task automatic test_halfband_no_idling();
      run_stream(MODE_HALFBAND, 0, 0);
   endtask

   task automatic test_full_band_sender_gaps();
      run_stream(MODE_FULL, 80, 0);
   endtask

   task automatic test_halfband_receiver_stalls();
      run_stream(MODE_HALFBAND, 0, 80);
   endtask

   task automatic test_full_band_both_idle();
      run_stream(MODE_FULL, 23, 23);
   endtask

   initial begin
      for (int i = 0; i < TAP_SPAN; i++) begin
         line_re[i] = '0;
         line_im[i] = '0;
      end
      for (int i = 0; i < HALF_SPAN; i++) coef_tab[i] = '0;
      halfband_model = MODE_FULL;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_words();
      test_halfband_no_idling();
      test_full_band_sender_gaps();
      test_halfband_receiver_stalls();
      test_full_band_both_idle();

      wait_idle();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+rtl
rtl/sfir_pkg.sv
rtl/sfir_cell.sv
rtl/sfir_coef_cell.sv
rtl/sfir_mac.sv
rtl/symmetric_complex_fir.sv
dv/tb_top.sv
